>>> hw/rtl/jpeg_scan_start_finder_defines.svh
// Assertion macros used by the checker of the scan start finder.
`ifndef JPEG_SCAN_START_FINDER_DEFINES_SVH
`define JPEG_SCAN_START_FINDER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define JSS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define JSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/jss_pkg.sv
package jss_pkg;

  // Width of the byte position counter; it saturates at its maximum.
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LEN_BITS    = 32;
  localparam int unsigned OUT_BITS    = 32;
  // Compare width: wide enough for position plus a 16-bit length, no wrap.
  localparam int unsigned CMP_W = ((OFFSET_BITS > LEN_BITS) ? OFFSET_BITS : LEN_BITS) + 2;

  localparam logic [2:0] ST_SEARCH     = 3'd0;
  localparam logic [2:0] ST_FOUND      = 3'd1;
  localparam logic [2:0] ST_BAD_START  = 3'd2;
  localparam logic [2:0] ST_MISALIGNED = 3'd3;
  localparam logic [2:0] ST_END_EARLY  = 3'd4;
  localparam logic [2:0] ST_TRUNCATED  = 3'd5;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd6;
  localparam logic [2:0] ST_MISSING    = 3'd7;

  localparam logic [7:0] BYTE_FILL = 8'hff;
  localparam logic [7:0] BYTE_SOI  = 8'hd8;
  localparam logic [7:0] BYTE_EOI  = 8'hd9;
  localparam logic [7:0] BYTE_SOS  = 8'hda;
  localparam logic [7:0] BYTE_RST0 = 8'hd0;
  localparam logic [7:0] BYTE_RST7 = 8'hd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
  } item_t;

  typedef struct packed {
    logic [2:0]          status;
    logic [OUT_BITS-1:0] scan_offset;
  } result_t;

endpackage

>>> hw/rtl/jss_in_reg.sv
module jss_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  jss_pkg::item_t item_i,
  input  logic          adv_i,
  output logic          valid_o,
  output jss_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  logic           in_fire;
  jss_pkg::item_t item_q;

  assign in_stall_o = valid_q & ~adv_i;
  assign in_fire    = in_valid_i & ~in_stall_o;
  assign valid_d    = in_fire | (valid_q & ~adv_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

>>> hw/rtl/jss_parser.sv
module jss_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   fire_i,
  input  jss_pkg::item_t          item_i,
  input  logic [jss_pkg::LEN_BITS-1:0] file_length_i,
  output jss_pkg::result_t        result_o
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SOI1   = 3'd1;
  localparam logic [2:0] PH_ALIGN  = 3'd2;
  localparam logic [2:0] PH_FILL   = 3'd3;
  localparam logic [2:0] PH_LEN_HI = 3'd4;
  localparam logic [2:0] PH_LEN_LO = 3'd5;
  localparam logic [2:0] PH_SKIP   = 3'd6;

  localparam int unsigned PW = jss_pkg::OFFSET_BITS;
  localparam int unsigned CW = jss_pkg::CMP_W;
  localparam int unsigned OW = jss_pkg::OUT_BITS;

  logic [2:0]    phase_q, phase_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [7:0]    len_hi_q, len_hi_d;
  logic [15:0]   skip_q, skip_d;
  logic          seen_q, seen_d;
  logic [2:0]    held_st_q, held_st_d;
  logic [OW-1:0] held_off_q, held_off_d;

  logic [PW-1:0] p;
  logic [CW-1:0] p_w, len_w, seg_w, end_w;
  logic [15:0]   seg, skip_dec;
  logic [7:0]    b;
  logic          vd;
  logic [2:0]    vd_st;
  logic          ignore;
  logic          room5;

  assign b     = item_i.data_byte;
  assign len_w = CW'(file_length_i);
  assign seg   = {len_hi_q, b};
  assign seg_w = CW'(seg);
  assign skip_dec = (skip_q != 16'd0) ? (skip_q - 16'd1) : skip_q;

  always_comb begin
    phase_d    = phase_q;
    len_hi_d   = len_hi_q;
    skip_d     = skip_q;
    seen_d     = seen_q;
    held_st_d  = held_st_q;
    held_off_d = held_off_q;
    vd         = 1'b0;
    vd_st      = jss_pkg::ST_SEARCH;
    ignore     = 1'b0;
    p          = pos_q;

    if (item_i.start_of_file) begin
      p          = '0;
      len_hi_d   = '0;
      skip_d     = '0;
      seen_d     = 1'b0;
      held_st_d  = jss_pkg::ST_SEARCH;
      held_off_d = '0;
      phase_d    = PH_SOI1;
    end
    p_w   = CW'(p);
    room5 = (p_w + CW'(5)) <= len_w;
    // Segment end, counted from the byte after the marker (p - 1).
    end_w = p_w - CW'(1) + seg_w;

    if (item_i.start_of_file) begin
      if (file_length_i < jss_pkg::LEN_BITS'(4) || b != jss_pkg::BYTE_FILL) begin
        vd    = 1'b1;
        vd_st = jss_pkg::ST_BAD_START;
      end
    end else begin
      unique case (phase_q)
        PH_SOI1: begin
          if (b != jss_pkg::BYTE_SOI) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_BAD_START;
          end else if (!room5) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_MISSING;
          end else begin
            phase_d = PH_ALIGN;
          end
        end
        PH_ALIGN: begin
          if (b != jss_pkg::BYTE_FILL) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_MISALIGNED;
          end else begin
            phase_d = PH_FILL;
            if ((p_w + CW'(2)) > len_w) begin
              vd    = 1'b1;
              vd_st = jss_pkg::ST_MISSING;
            end
          end
        end
        PH_FILL: begin
          priority if (b == jss_pkg::BYTE_FILL) begin
            if ((p_w + CW'(2)) > len_w) begin
              vd    = 1'b1;
              vd_st = jss_pkg::ST_MISSING;
            end
          end else if (b == jss_pkg::BYTE_EOI) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_END_EARLY;
          end else if (b == jss_pkg::BYTE_SOI ||
                       (b >= jss_pkg::BYTE_RST0 && b <= jss_pkg::BYTE_RST7)) begin
            if (!room5) begin
              vd    = 1'b1;
              vd_st = jss_pkg::ST_MISSING;
            end else begin
              phase_d = PH_ALIGN;
            end
          end else if ((p_w + CW'(3)) > len_w) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_TRUNCATED;
          end else begin
            seen_d  = (b == jss_pkg::BYTE_SOS);
            phase_d = PH_LEN_HI;
          end
        end
        PH_LEN_HI: begin
          len_hi_d = b;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          if (seg < 16'd2 || end_w > len_w) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_BAD_LENGTH;
          end else if (seen_q) begin
            vd    = 1'b1;
            vd_st = jss_pkg::ST_FOUND;
          end else if (seg == 16'd2) begin
            if (!room5) begin
              vd    = 1'b1;
              vd_st = jss_pkg::ST_MISSING;
            end else begin
              phase_d = PH_ALIGN;
            end
          end else begin
            skip_d  = seg - 16'd2;
            phase_d = PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 16'd0) begin
            if (!room5) begin
              vd    = 1'b1;
              vd_st = jss_pkg::ST_MISSING;
            end else begin
              phase_d = PH_ALIGN;
            end
          end
        end
        default: begin
          // Idle: ignore the byte and repeat the held verdict.
          ignore = 1'b1;
        end
      endcase
    end

    if (vd) begin
      phase_d    = PH_IDLE;
      held_st_d  = vd_st;
      held_off_d = (vd_st == jss_pkg::ST_FOUND) ? OW'(end_w) : '0;
    end

    pos_d = pos_q;
    if (!ignore) begin
      pos_d = (p != {PW{1'b1}}) ? (p + PW'(1)) : p;
    end

    if (ignore) begin
      result_o.status      = held_st_q;
      result_o.scan_offset = held_off_q;
    end else begin
      result_o.status      = vd_st;
      result_o.scan_offset = (vd_st == jss_pkg::ST_FOUND) ? held_off_d : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      pos_q      <= '0;
      len_hi_q   <= '0;
      skip_q     <= '0;
      seen_q     <= 1'b0;
      held_st_q  <= jss_pkg::ST_SEARCH;
      held_off_q <= '0;
    end else if (fire_i) begin
      phase_q    <= phase_d;
      pos_q      <= pos_d;
      len_hi_q   <= len_hi_d;
      skip_q     <= skip_d;
      seen_q     <= seen_d;
      held_st_q  <= held_st_d;
      held_off_q <= held_off_d;
    end
  end

endmodule

>>> hw/rtl/jss_out_reg.sv
module jss_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  jss_pkg::result_t  result_i,
  input  logic             out_stall_i,
  output logic             free_o,
  output logic             out_valid_o,
  output jss_pkg::result_t  result_o
);

  logic             valid_q, valid_d;
  jss_pkg::result_t result_q;

  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

>>> hw/rtl/jpeg_scan_start_finder.sv
// JPEG scan start finder. Feed the file one byte per word, with
// start_of_file_i set on byte 0; every byte yields exactly one result word.
// status_o reads 0 while still searching, 1 once an SOS segment length is
// accepted (scan_offset_o then holds the offset just past that segment),
// and 2..7 for bad start, misaligned marker, EOI before scan, truncated
// length, bad length and missing scan. Once a verdict is given it repeats on
// every further byte until the next start_of_file_i. Write file_length over
// the cfg port before the file's bytes, while the block is idle. Throughput
// is one byte per clock while out_stall_i is low; bytes pass the input
// register, parse logic and result register. cfg_ready_o is always high.
module jpeg_scan_start_finder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // byte input
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 data_byte_i,
  input  logic                       start_of_file_i,
  // result output
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [jss_pkg::OUT_BITS-1:0] scan_offset_o,
  // file length register write
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [jss_pkg::LEN_BITS-1:0] cfg_file_length_i
);

  logic [jss_pkg::LEN_BITS-1:0] file_length_q;

  jss_pkg::item_t   in_item, s1_item;
  jss_pkg::result_t parse_res, out_res;
  logic             s1_valid, s2_free, s1_fire;

  // Config register, always ready.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      file_length_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      file_length_q <= cfg_file_length_i;
    end
  end

  assign in_item.data_byte     = data_byte_i;
  assign in_item.start_of_file = start_of_file_i;

  // Stage 1: input register; moves on whenever the result register frees up.
  jss_in_reg u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .adv_i      (s2_free),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  assign s1_fire = s1_valid & s2_free;

  // Parse state advances exactly once per byte, when it moves to stage 2.
  jss_parser u_parse (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .fire_i        (s1_fire),
    .item_i        (s1_item),
    .file_length_i (file_length_q),
    .result_o      (parse_res)
  );

  // Stage 2: result register.
  jss_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_fire),
    .result_i    (parse_res),
    .out_stall_i (out_stall_i),
    .free_o      (s2_free),
    .out_valid_o (out_valid_o),
    .result_o    (out_res)
  );

  assign status_o      = out_res.status;
  assign scan_offset_o = out_res.scan_offset;

endmodule

>>> hw/rtl/jss_checker.sv
`include "jpeg_scan_start_finder_defines.svh"

module jss_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic [2:0]                 status_o,
  input logic [jss_pkg::OUT_BITS-1:0] scan_offset_o
);

  `JSS_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(status_o) && $stable(scan_offset_o),
    "stalled result word changed")

  // Input side backs up only when a result word is waiting.
  `JSS_ASSERT_NOW(a_stall_needs_out, in_stall_o, out_valid_o,
    "input stalled with no result pending")

  // An accepted byte passes the input and result registers to the output if not blocked.
  `JSS_ASSERT_NEXT(a_latency, (in_valid_i && !in_stall_o) ##1 (!out_valid_o || !out_stall_i),
    out_valid_o, "accepted byte produced no result word")

  `JSS_ASSERT_NOW(a_offset_zero, out_valid_o && status_o != jss_pkg::ST_FOUND,
    scan_offset_o == '0, "scan offset set without a found verdict")

endmodule

bind jpeg_scan_start_finder jss_checker u_jss_checker (.*);
